### design/boot_state_select_loop_guard_unit_defines.svh
// Assertion macros for the boot state select loop guard unit.
// Used by the top level; needs a clock and reset signal in scope.
`ifndef BOOT_STATE_SELECT_LOOP_GUARD_UNIT_DEFINES_SVH
`define BOOT_STATE_SELECT_LOOP_GUARD_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define BSSG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bssg assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define BSSG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bssg assertion failed");

`endif

### design/bssg_pkg.sv
// Shared types and constants for the boot state select loop guard unit.
// No dependencies.
package bssg_pkg;

   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int LIMIT_W  = 8;
   localparam int WINDOW_W = 16;
   localparam int REASON_W = 4;
   localparam int MODE_W   = 3;
   localparam int STATE_W  = 3;
   localparam int MALF_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // boot states
   localparam logic [STATE_W-1:0] ST_USER  = 3'd0;
   localparam logic [STATE_W-1:0] ST_DEAD  = 3'd1;
   localparam logic [STATE_W-1:0] ST_FLASH = 3'd2;
   localparam logic [STATE_W-1:0] ST_LOCAL = 3'd3;
   localparam logic [STATE_W-1:0] ST_TEST  = 3'd4;
   localparam logic [STATE_W-1:0] ST_MALF  = 3'd5;

   // malfunction causes
   localparam logic [MALF_W-1:0] MALF_NONE      = 3'd0;
   localparam logic [MALF_W-1:0] MALF_NO_REASON = 3'd1;
   localparam logic [MALF_W-1:0] MALF_SECVIO    = 3'd2;
   localparam logic [MALF_W-1:0] MALF_UNKNOWN   = 3'd3;
   localparam logic [MALF_W-1:0] MALF_BOOT_LOOP = 3'd4;
   localparam logic [MALF_W-1:0] MALF_WD_LOOP   = 3'd5;

   // boot reasons
   localparam logic [REASON_W-1:0] RSN_UNREADABLE = 4'd0;
   localparam logic [REASON_W-1:0] RSN_SWDG       = 4'd1;
   localparam logic [REASON_W-1:0] RSN_SECVIO     = 4'd2;
   localparam logic [REASON_W-1:0] RSN_WD32K      = 4'd3;
   localparam logic [REASON_W-1:0] RSN_POR        = 4'd4;
   localparam logic [REASON_W-1:0] RSN_PWRKEY     = 4'd5;
   localparam logic [REASON_W-1:0] RSN_CHARGER    = 4'd7;
   localparam logic [REASON_W-1:0] RSN_USB        = 4'd8;
   localparam logic [REASON_W-1:0] RSN_SWRESET    = 4'd9;
   localparam logic [REASON_W-1:0] RSN_RTC        = 4'd10;
   localparam logic [REASON_W-1:0] RSN_NSU        = 4'd11;

   // boot modes
   localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOCAL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TEST   = 3'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOT_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WD_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOT_WINDOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WD_TIME = 3'd4;

   // register reset values
   localparam logic [LIMIT_W-1:0]  RST_BOOT_LIMIT  = 8'd5;
   localparam logic [LIMIT_W-1:0]  RST_WD_LIMIT    = 8'd6;
   localparam logic [WINDOW_W-1:0] RST_BOOT_WINDOW = 16'd120;
   localparam logic [WINDOW_W-1:0] RST_MIN_WD_TIME = 16'd600;

   typedef struct packed {
      logic                force_mode;
      logic [LIMIT_W-1:0]  boot_limit;
      logic [LIMIT_W-1:0]  wd_limit;
      logic [WINDOW_W-1:0] boot_window;
      logic [WINDOW_W-1:0] wd_window;
   } cfg_type;

   typedef struct packed {
      logic [STATE_W-1:0] boot_state;
      logic [MALF_W-1:0]  malf_reason;
      logic               cnt_boots;
      logic               cnt_wd;
   } decode_type;

   typedef struct packed {
      logic               saved_dead;
      logic [MALF_W-1:0]  loop_cause;
      logic [COUNT_W-1:0] boot_tally;
      logic [COUNT_W-1:0] wd_count;
   } guard_status_type;

endpackage

### design/bssg_decode.sv
// Boot mode and reason decode: picks the boot state, the direct cause and
// which counters the event advances. Depends on bssg_pkg.
module bssg_decode (
   input  logic [bssg_pkg::REASON_W-1:0] reason_code,
   input  logic [bssg_pkg::MODE_W-1:0]   mode_code,
   input  logic                          saved_dead,
   output bssg_pkg::decode_type          dec
);

   always_comb begin
      dec.boot_state  = bssg_pkg::ST_USER;
      dec.malf_reason = bssg_pkg::MALF_NONE;
      dec.cnt_boots   = 1'b1;
      dec.cnt_wd      = 1'b0;
      case (mode_code)
         bssg_pkg::MODE_UPDATE: dec.boot_state = bssg_pkg::ST_FLASH;
         bssg_pkg::MODE_LOCAL:  dec.boot_state = bssg_pkg::ST_LOCAL;
         bssg_pkg::MODE_TEST:   dec.boot_state = bssg_pkg::ST_TEST;
         default: begin
            case (reason_code)
               bssg_pkg::RSN_UNREADABLE: begin
                  dec.boot_state  = bssg_pkg::ST_MALF;
                  dec.malf_reason = bssg_pkg::MALF_NO_REASON;
               end
               bssg_pkg::RSN_SECVIO: begin
                  dec.boot_state  = bssg_pkg::ST_MALF;
                  dec.malf_reason = bssg_pkg::MALF_SECVIO;
               end
               bssg_pkg::RSN_POR, bssg_pkg::RSN_PWRKEY: begin
                  dec.boot_state = bssg_pkg::ST_USER;
                  dec.cnt_boots  = 1'b0;
               end
               bssg_pkg::RSN_SWDG, bssg_pkg::RSN_WD32K: begin
                  dec.boot_state = bssg_pkg::ST_USER;
                  dec.cnt_wd     = 1'b1;
               end
               bssg_pkg::RSN_SWRESET:
                  dec.boot_state = saved_dead ? bssg_pkg::ST_DEAD : bssg_pkg::ST_USER;
               bssg_pkg::RSN_NSU:
                  dec.boot_state = bssg_pkg::ST_USER;
               bssg_pkg::RSN_CHARGER, bssg_pkg::RSN_USB, bssg_pkg::RSN_RTC:
                  dec.boot_state = bssg_pkg::ST_DEAD;
               default: begin
                  dec.boot_state  = bssg_pkg::ST_MALF;
                  dec.malf_reason = bssg_pkg::MALF_UNKNOWN;
               end
            endcase
         end
      endcase
   end

endmodule

### design/bssg_guard.sv
// Loop guard: saved state, boot and watchdog counters, last boot time.
// Works out the loop cause of the current word. Depends on bssg_pkg.
module bssg_guard (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  bssg_pkg::cfg_type           cfg,
   input  bssg_pkg::decode_type        dec,
   input  logic [bssg_pkg::TIME_W-1:0] now_seconds,
   output bssg_pkg::guard_status_type  status
);

   localparam int PAD_W = bssg_pkg::TIME_W - bssg_pkg::WINDOW_W;

   logic                         saved_dead_ff, saved_dead_in;
   logic [bssg_pkg::COUNT_W-1:0] boot_tally_ff, boot_tally_in;
   logic [bssg_pkg::COUNT_W-1:0] wd_count_ff, wd_count_in;
   logic [bssg_pkg::TIME_W-1:0]  last_time_ff, last_time_in;

   logic [bssg_pkg::TIME_W-1:0]  elapsed;
   logic [bssg_pkg::COUNT_W-1:0] boot_next, wd_next;
   logic                         boot_loop, wd_loop;
   logic [bssg_pkg::MALF_W-1:0]  cause;

   assign elapsed = now_seconds - last_time_ff;

   always_comb begin
      boot_next = '0;
      wd_next   = '0;
      if (dec.cnt_boots && (elapsed < {{PAD_W{1'b0}}, cfg.boot_window})) begin
         boot_next = (&boot_tally_ff) ? boot_tally_ff
                                      : boot_tally_ff + bssg_pkg::COUNT_W'(1);
      end
      if (dec.cnt_wd && (elapsed < {{PAD_W{1'b0}}, cfg.wd_window})) begin
         wd_next = (&wd_count_ff) ? wd_count_ff : wd_count_ff + bssg_pkg::COUNT_W'(1);
      end
      boot_loop = dec.cnt_boots && (boot_next > cfg.boot_limit);
      wd_loop   = dec.cnt_wd && (wd_next > cfg.wd_limit);
      // watchdog loop wins over reboot loop
      if (wd_loop) begin
         cause = bssg_pkg::MALF_WD_LOOP;
      end else if (boot_loop) begin
         cause = bssg_pkg::MALF_BOOT_LOOP;
      end else begin
         cause = bssg_pkg::MALF_NONE;
      end
   end

   always_comb begin
      saved_dead_in = saved_dead_ff;
      boot_tally_in = boot_tally_ff;
      wd_count_in   = wd_count_ff;
      last_time_in  = last_time_ff;
      if (advance && cfg.force_mode) begin
         if (dec.boot_state == bssg_pkg::ST_USER) begin
            saved_dead_in = 1'b0;
         end else if (dec.boot_state == bssg_pkg::ST_DEAD) begin
            saved_dead_in = 1'b1;
         end
         // a detected loop clears both counters
         boot_tally_in = (wd_loop || boot_loop) ? '0 : boot_next;
         wd_count_in   = (wd_loop || boot_loop) ? '0 : wd_next;
         last_time_in  = now_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saved_dead_ff <= 1'b0;
         boot_tally_ff <= '0;
         wd_count_ff   <= '0;
         last_time_ff  <= '0;
      end else begin
         saved_dead_ff <= saved_dead_in;
         boot_tally_ff <= boot_tally_in;
         wd_count_ff   <= wd_count_in;
         last_time_ff  <= last_time_in;
      end
   end

   assign status.saved_dead = saved_dead_ff;
   assign status.loop_cause = cause;
   assign status.boot_tally = boot_tally_ff;
   assign status.wd_count   = wd_count_ff;

endmodule

### design/boot_state_select_loop_guard_unit.sv
// Boot state select loop guard unit, top level.
// An accepted word is first held in the input register, then moves to the
// result register, whose contents are presented on rsp.
// Throughput: one word per cycle unless rsp stalls; the input register moves to the result
// register, and the guard state updates, in the same cycle.
// Reset is synchronous, active high: clears valids, guard state and sets
// the configuration registers to their defaults.
`include "boot_state_select_loop_guard_unit_defines.svh"

module boot_state_select_loop_guard_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] reason_code, [6:4] mode_code, [38:7] now_seconds, [39] zero
   input  logic [bssg_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] boot_state, [5:3] malf_reason, [7:6] zero
   output logic [bssg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [bssg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bssg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bssg_pkg::cfg_type cfg_ff, cfg_in;

   logic                          in_vld_ff, in_vld_in;
   logic [bssg_pkg::REASON_W-1:0] reason_ff;
   logic [bssg_pkg::MODE_W-1:0]   mode_ff;
   logic [bssg_pkg::TIME_W-1:0]   now_ff;

   logic                          out_vld_ff, out_vld_in;
   logic [bssg_pkg::STATE_W-1:0]  state_ff;
   logic [bssg_pkg::MALF_W-1:0]   malf_ff, malf_in;

   logic                          out_open, move, take;
   bssg_pkg::decode_type          dec;
   bssg_pkg::guard_status_type    status;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bssg_pkg::CSR_FORCE_MODE:  cfg_in.force_mode = csr_wdata[0];
            bssg_pkg::CSR_BOOT_LIMIT:  cfg_in.boot_limit = csr_wdata[bssg_pkg::LIMIT_W-1:0];
            bssg_pkg::CSR_WD_LIMIT:
               cfg_in.wd_limit = csr_wdata[bssg_pkg::LIMIT_W-1:0];
            bssg_pkg::CSR_BOOT_WINDOW:
               cfg_in.boot_window = csr_wdata[bssg_pkg::WINDOW_W-1:0];
            bssg_pkg::CSR_MIN_WD_TIME:
               cfg_in.wd_window = csr_wdata[bssg_pkg::WINDOW_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.force_mode  <= 1'b0;
         cfg_ff.boot_limit  <= bssg_pkg::RST_BOOT_LIMIT;
         cfg_ff.wd_limit    <= bssg_pkg::RST_WD_LIMIT;
         cfg_ff.boot_window <= bssg_pkg::RST_BOOT_WINDOW;
         cfg_ff.wd_window   <= bssg_pkg::RST_MIN_WD_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline handshake
   assign out_open   = !out_vld_ff || rsp_tready;
   assign move       = in_vld_ff && out_open;
   assign req_tready = !in_vld_ff || out_open;
   assign take       = req_tvalid && req_tready;
   assign in_vld_in  = take || (in_vld_ff && !out_open);
   assign out_vld_in = move || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         reason_ff <= req_tdata[3:0];
         mode_ff   <= req_tdata[6:4];
         now_ff    <= req_tdata[38:7];
      end
   end

   bssg_decode u_decode (
      .reason_code (reason_ff),
      .mode_code   (mode_ff),
      .saved_dead  (status.saved_dead),
      .dec         (dec)
   );

   bssg_guard u_guard (
      .clock       (clock),
      .reset       (reset),
      .advance     (move),
      .cfg         (cfg_ff),
      .dec         (dec),
      .now_seconds (now_ff),
      .status      (status)
   );

   // a direct cause is never replaced by a loop cause
   always_comb begin
      if (!cfg_ff.force_mode) begin
         malf_in = bssg_pkg::MALF_NONE;
      end else if (dec.malf_reason != bssg_pkg::MALF_NONE) begin
         malf_in = dec.malf_reason;
      end else begin
         malf_in = status.loop_cause;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         state_ff <= dec.boot_state;
         malf_ff  <= malf_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, malf_ff, state_ff};

   `BSSG_ASSERT_NEXT(a_move_fills_out, move, out_vld_ff)
   `BSSG_ASSERT_NEXT(a_stall_keeps_in, in_vld_ff && !out_open, in_vld_ff)
   `BSSG_ASSERT_NEXT(a_loop_clears_counts, move && cfg_ff.force_mode && (status.loop_cause != bssg_pkg::MALF_NONE), (status.boot_tally == '0) && (status.wd_count == '0))
   `BSSG_ASSERT_NOW(a_malf_in_range, out_vld_ff, malf_ff <= bssg_pkg::MALF_WD_LOOP)

endmodule
